>>> hdl/tatt_pkg.sv
// ----------------------------------------------------------------------------
// tatt_pkg: shared types and constants of the angle-to-time block
// Holds the configuration and job structures, the branch codes and the sizes
// used by the front, the queue, the square root pipeline and the back end.
// ----------------------------------------------------------------------------
package tatt_pkg;

  localparam int ANGLE_W       = 32;
  localparam int TIME_W        = 48;
  localparam int PROD_W        = 64;
  localparam int ROOT_W        = 32;
  localparam int REM_W         = 36;
  localparam int SQRT_STAGES   = 32;
  localparam int QUEUE_DEPTH   = 4;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [ANGLE_W-1:0] TWO_OVER_ACCEL_RST = 32'd131072;
  localparam logic [ANGLE_W-1:0] INV_SPEED_RST      = 32'd65536;
  localparam logic [ANGLE_W-1:0] ACCEL_ANGLE_RST    = 32'd32768;
  localparam logic [ANGLE_W-1:0] TOTAL_ANGLE_RST    = 32'd2058874;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_TWO_OVER_ACCEL = 2'd0;
  localparam logic [1:0] REG_INV_SPEED      = 2'd1;
  localparam logic [1:0] REG_ACCEL_ANGLE    = 2'd2;
  localparam logic [1:0] REG_TOTAL_ANGLE    = 2'd3;

  // Segment of the velocity profile that an item falls into.
  typedef enum logic [1:0] {
    MODE_ACCEL    = 2'd0,
    MODE_CRUISE   = 2'd1,
    MODE_TRI_DEC  = 2'd2,
    MODE_TRAP_DEC = 2'd3
  } mode_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] two_over_accel;
    logic [ANGLE_W-1:0] inv_speed;
    logic [ANGLE_W-1:0] accel_angle;
    logic [ANGLE_W-1:0] total_angle;
  } cfg_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] sq_op;   // angle fed to the data-dependent square root
    logic [ANGLE_W-1:0] cr_op;   // angle fed to the cruise product
    logic               ta_tri;  // peak time uses the triangular radicand
    mode_t              mode;
    logic               sat;     // angle was clamped
  } job_t;

endpackage

>>> hdl/tatt_front.sv
// ----------------------------------------------------------------------------
// tatt_front: item classification
// Clamps the angle and decides which profile segment it lies in, producing
// the operands that the back end multiplies and takes roots of.
// ----------------------------------------------------------------------------
module tatt_front (
  input  logic [tatt_pkg::ANGLE_W-1:0] angle,
  input  tatt_pkg::cfg_t               cfg,
  output tatt_pkg::job_t               job
);

  localparam int AW = tatt_pkg::ANGLE_W;

  logic [AW-1:0] a;
  logic [AW-1:0] len;
  logic [AW-1:0] la;
  logic          clamp;
  logic          tri_prof;
  logic [AW:0]   two_a;
  logic [AW:0]   two_la;

  assign len      = cfg.total_angle;
  assign la       = cfg.accel_angle;
  assign clamp    = angle > len;
  assign a        = clamp ? len : angle;
  assign two_a    = {a, 1'b0};
  assign two_la   = {la, 1'b0};
  assign tri_prof = two_la > {1'b0, len};

  always_comb begin
    job.sat    = clamp;
    job.sq_op  = a;
    job.cr_op  = '0;
    job.ta_tri = tri_prof;
    job.mode   = tatt_pkg::MODE_ACCEL;
    if (tri_prof) begin
      if (two_a > {1'b0, len}) begin
        job.mode  = tatt_pkg::MODE_TRI_DEC;
        job.sq_op = len - a;
      end
    end else begin
      if (a <= la) begin
        job.mode = tatt_pkg::MODE_ACCEL;
      end else if (a < len - la) begin
        job.mode  = tatt_pkg::MODE_CRUISE;
        job.cr_op = a - la;
      end else begin
        // In this profile 2*accel_angle does not exceed the total angle.
        job.mode  = tatt_pkg::MODE_TRAP_DEC;
        job.cr_op = len - two_la[AW-1:0];
        job.sq_op = len - a;
      end
    end
  end

endmodule

>>> hdl/tatt_queue.sv
// ----------------------------------------------------------------------------
// tatt_queue: job queue
// A small register FIFO that decouples classification from the back end.
// ----------------------------------------------------------------------------
module tatt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tatt_pkg::job_t wr_job,
  input  logic           pop,
  output tatt_pkg::job_t rd_job,
  output logic           full,
  output logic           empty
);

  localparam int DEPTH = tatt_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  tatt_pkg::job_t  mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full   = count_r == CW'(DEPTH);
  assign empty  = count_r == '0;
  assign rd_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue fill count lost a push");

endmodule

>>> hdl/tatt_sqrt.sv
// ----------------------------------------------------------------------------
// tatt_sqrt: pipelined integer square root
// Restoring digit recurrence, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module tatt_sqrt (
  input  logic                         clk,
  input  logic [tatt_pkg::PROD_W-1:0]  rad,
  output logic [tatt_pkg::ROOT_W-1:0]  root
);

  localparam int STAGES = tatt_pkg::SQRT_STAGES;
  localparam int XW     = tatt_pkg::PROD_W;
  localparam int RW     = tatt_pkg::ROOT_W;
  localparam int MW     = tatt_pkg::REM_W;

  logic [MW-1:0] rem_r  [STAGES-1];
  logic [XW-1:0] x_r    [STAGES-1];
  logic [RW-1:0] root_r [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [MW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [XW-1:0] x_in;
    logic [MW-1:0] rem_sh;
    logic [MW-1:0] trial;
    logic          take;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = rad;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign x_in    = x_r[s-1];
    end

    assign rem_sh = {rem_in[MW-3:0], x_in[XW-1 -: 2]};
    assign trial  = {{(MW-RW-2){1'b0}}, root_in, 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      root_r[s] <= {root_in[RW-2:0], take};
    end

    if (s < STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[s] <= take ? rem_sh - trial : rem_sh;
        x_r[s]   <= {x_in[XW-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[STAGES-1];

endmodule

>>> hdl/tatt_back.sv
// ----------------------------------------------------------------------------
// tatt_back: arithmetic back end
// Multiplies the operands, runs two square root pipelines side by side and
// combines the segment terms into a saturated time.
// ----------------------------------------------------------------------------
module tatt_back #(
  parameter int FRAC_BITS = tatt_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pop,
  input  tatt_pkg::job_t               job,
  input  tatt_pkg::cfg_t               cfg,
  output logic                         out_valid,
  output logic [tatt_pkg::TIME_W-1:0]  out_time,
  output logic                         out_sat
);

  localparam int STAGES = tatt_pkg::SQRT_STAGES;
  localparam int PW     = tatt_pkg::PROD_W;
  localparam int RW     = tatt_pkg::ROOT_W;
  localparam int TW     = tatt_pkg::TIME_W;
  localparam int CRW    = PW - FRAC_BITS;
  localparam int LAT    = STAGES + 2;

  // Multiply stage.
  logic                  m_valid_r;
  tatt_pkg::mode_t       m_mode_r;
  logic                  m_sat_r;
  logic                  m_tri_r;
  logic [PW-1:0]         m_sq_prod_r;
  logic [PW-1:0]         m_ta_prod_r;
  logic [PW-1:0]         m_cr_prod_r;
  logic [PW-1:0]         ta_rad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    m_mode_r    <= job.mode;
    m_sat_r     <= job.sat;
    m_tri_r     <= job.ta_tri;
    m_sq_prod_r <= PW'(job.sq_op) * PW'(cfg.two_over_accel);
    m_ta_prod_r <= PW'(job.ta_tri ? cfg.total_angle : cfg.accel_angle)
                   * PW'(cfg.two_over_accel);
    m_cr_prod_r <= PW'(job.cr_op) * PW'(cfg.inv_speed);
  end

  assign ta_rad = m_tri_r ? {1'b0, m_ta_prod_r[PW-1:1]} : m_ta_prod_r;

  logic [RW-1:0] s_root;
  logic [RW-1:0] ta_root;

  tatt_sqrt u_sqrt_s (
    .clk  (clk),
    .rad  (m_sq_prod_r),
    .root (s_root)
  );

  tatt_sqrt u_sqrt_ta (
    .clk  (clk),
    .rad  (ta_rad),
    .root (ta_root)
  );

  // Side band that travels beside the roots.
  logic            v_r    [STAGES];
  tatt_pkg::mode_t mode_r [STAGES];
  logic            sat_r  [STAGES];
  logic [CRW-1:0]  cr_r   [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_side
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s] <= 1'b0;
        end else begin
          v_r[s] <= m_valid_r;
        end
      end
      always_ff @(posedge clk) begin
        mode_r[s] <= m_mode_r;
        sat_r[s]  <= m_sat_r;
        cr_r[s]   <= m_cr_prod_r[PW-1:FRAC_BITS];
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s] <= 1'b0;
        end else begin
          v_r[s] <= v_r[s-1];
        end
      end
      always_ff @(posedge clk) begin
        mode_r[s] <= mode_r[s-1];
        sat_r[s]  <= sat_r[s-1];
        cr_r[s]   <= cr_r[s-1];
      end
    end
  end

  // Combine stage, modulo 2^64 like the defining arithmetic.
  logic [PW-1:0] s64, ta64, ta2, c64, t64;
  logic          over;

  assign s64  = PW'(s_root);
  assign ta64 = PW'(ta_root);
  assign ta2  = {ta64[PW-2:0], 1'b0};
  assign c64  = PW'(cr_r[STAGES-1]);

  always_comb begin
    case (mode_r[STAGES-1])
      tatt_pkg::MODE_ACCEL:   t64 = s64;
      tatt_pkg::MODE_CRUISE:  t64 = ta64 + c64;
      tatt_pkg::MODE_TRI_DEC: t64 = ta2 - s64;
      default:                t64 = ta2 + c64 - s64;
    endcase
  end

  assign over = t64[PW-1:TW] != '0;

  logic          out_valid_r;
  logic [TW-1:0] out_time_r;
  logic          out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v_r[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    out_time_r <= over ? {TW{1'b1}} : t64[TW-1:0];
    out_sat_r  <= sat_r[STAGES-1] | over;
  end

  assign out_valid = out_valid_r;
  assign out_time  = out_time_r;
  assign out_sat   = out_sat_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n) pop |-> ##LAT out_valid)
    else $error("job did not reach the output after the pipeline latency");

endmodule

>>> hdl/trapezoid_angle_to_time.sv
// ----------------------------------------------------------------------------
// trapezoid_angle_to_time: path angle to profile time
// Maps each path angle to the time at which a trapezoidal or triangular
// angular velocity profile reaches it, with an APB-style register port.
// ----------------------------------------------------------------------------
// The block takes one angle per clock cycle while busy is low. Each item
// passes through the job queue, one multiply stage and the 32-stage square
// root pipelines, one root bit per stage, and an output register. Results
// appear on out_node_time and out_saturated for exactly one cycle, marked by
// out_valid, and cannot be held off. Since the back end drains its queue
// every cycle, busy stays low in normal use; it rises only if the job queue
// is full. Registers may be written only while no item is in flight.
// ----------------------------------------------------------------------------
module trapezoid_angle_to_time #(
  parameter int FRAC_BITS = tatt_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input items.
  input  logic                          start,
  output logic                          busy,
  input  logic [tatt_pkg::ANGLE_W-1:0]  in_angle,
  // Results.
  output logic                          out_valid,
  output logic [tatt_pkg::TIME_W-1:0]   out_node_time,
  output logic                          out_saturated,
  // Register port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // Configuration registers. Each sits at byte address 4 * index, and the
  // write lands on the access cycle of the transfer.
  tatt_pkg::cfg_t cfg_r;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.two_over_accel <= tatt_pkg::TWO_OVER_ACCEL_RST;
      cfg_r.inv_speed      <= tatt_pkg::INV_SPEED_RST;
      cfg_r.accel_angle    <= tatt_pkg::ACCEL_ANGLE_RST;
      cfg_r.total_angle    <= tatt_pkg::TOTAL_ANGLE_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        tatt_pkg::REG_TWO_OVER_ACCEL: cfg_r.two_over_accel <= pwdata;
        tatt_pkg::REG_INV_SPEED:      cfg_r.inv_speed      <= pwdata;
        tatt_pkg::REG_ACCEL_ANGLE:    cfg_r.accel_angle    <= pwdata;
        default:                      cfg_r.total_angle    <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      tatt_pkg::REG_TWO_OVER_ACCEL: prdata = cfg_r.two_over_accel;
      tatt_pkg::REG_INV_SPEED:      prdata = cfg_r.inv_speed;
      tatt_pkg::REG_ACCEL_ANGLE:    prdata = cfg_r.accel_angle;
      default:                      prdata = cfg_r.total_angle;
    endcase
  end

  // Front: an accepted angle is classified in the same cycle and queued.
  tatt_pkg::job_t front_job;
  tatt_pkg::job_t back_job;
  logic           q_full;
  logic           q_empty;
  logic           push;
  logic           pop;

  assign busy = q_full;
  assign push = start && !busy;
  // The back end never stalls, so it takes a job whenever one is waiting.
  assign pop  = !q_empty;

  tatt_front u_front (
    .angle (in_angle),
    .cfg   (cfg_r),
    .job   (front_job)
  );

  tatt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (front_job),
    .pop    (pop),
    .rd_job (back_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  tatt_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (pop),
    .job       (back_job),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_time  (out_node_time),
    .out_sat   (out_saturated)
  );

endmodule
